/* rtl/core/lphs_pkg.sv */
// Shared constants for the linear probing hash set: request, status and
// slot tag codes, field widths and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package lphs_pkg;

    // field widths fixed by the interface
    localparam int REQ_W      = 2;
    localparam int KEY_IN_W   = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_IDX_W = 4;
    localparam int TAG_W      = 2;

    // parameter defaults
    localparam int TABLE_SIZE_DEF = 16;
    localparam int KEY_WIDTH_DEF  = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    // slot tags
    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_USED  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_DELETED  = 3'd5;

endpackage

/* rtl/core/lphs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lphs_home.sv */
// Home slot unit: key modulo table size. A mask for power-of-two sizes,
// otherwise a reciprocal multiplication, a remainder and a conditional subtract.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module lphs_home #(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_W      = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [KEY_W-1:0]              key_in,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] home
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam bit POW2  = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    logic done_reg;

    generate
        if (POW2) begin : g_mask
            logic [IDX_W-1:0] home_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else if (start) begin
                    done_reg <= 1'b1;
                end
                if (start) begin
                    home_reg <= IDX_W'(key_in);
                end
            end

            assign home = home_reg;
        end else begin : g_recip
            // quotient estimate k*M >> (N+IDX_W), M = floor(2^(N+IDX_W)/T),
            // is low by at most one, so one conditional subtract finishes
            localparam int N  = (KEY_W > IDX_W) ? KEY_W : IDX_W;
            localparam int NW = N + 1;
            localparam int QW = N - IDX_W + 1;
            localparam int PW = 2 * N + 1;
            localparam logic [63:0]    M_FULL = (64'd1 << (N + IDX_W)) / 64'(TABLE_SIZE);
            localparam logic [N:0]     M_C    = M_FULL[N:0];
            localparam logic [IDX_W:0] T_C    = (IDX_W + 1)'(TABLE_SIZE);

            logic [2:0]       stage_reg;
            logic [N-1:0]     k_reg;
            logic [QW-1:0]    q_reg;
            logic [IDX_W:0]   r_reg;
            logic [IDX_W-1:0] home_reg;
            logic [PW-1:0]    prod;
            logic [NW-1:0]    r_wide;

            assign prod   = PW'(k_reg) * PW'(M_C);
            // r = k - q*T lies in [0, 2T)
            assign r_wide = NW'(k_reg) - NW'(q_reg) * NW'(TABLE_SIZE);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg  <= 1'b0;
                    stage_reg <= '0;
                end else if (start) begin
                    done_reg  <= 1'b0;
                    stage_reg <= 3'b001;
                end else begin
                    stage_reg <= {stage_reg[1:0], 1'b0};
                    if (stage_reg[2]) begin
                        done_reg <= 1'b1;
                    end
                end
                if (start) begin
                    k_reg <= N'(key_in);
                end
                if (stage_reg[0]) begin
                    q_reg <= prod[PW-1 -: QW];
                end
                if (stage_reg[1]) begin
                    r_reg <= r_wide[IDX_W:0];
                end
                if (stage_reg[2]) begin
                    home_reg <= (r_reg >= T_C) ? IDX_W'(r_reg - T_C)
                                               : r_reg[IDX_W-1:0];
                end
            end

            assign home = home_reg;
        end
    endgenerate

    assign done = done_reg;

endmodule

/* rtl/core/linear_probe_hash_set.sv */
// Linear probing hash set with tombstones: top level, probe sequencer.
// Depends on lphs_pkg, lphs_home and lphs_ram.
`timescale 1ns / 1ps
//
//  channel  dir  ports (tdata / tuser)                  word
//  s_axis   in   tdata[31:0] key, tuser[1:0] req_type   one request
//  m_axis   out  tdata[3:0] slot_index, tuser[2:0] status  one result
//
// One request at a time. The home slot comes from a mask for a power-of-two
// TABLE_SIZE, else from the three-stage reciprocal remainder; then the first
// slot is read. The probe then reads one slot per cycle from the slot RAM
// (single read port), up to TABLE_SIZE reads, and a finish step does the
// write-back and loads the result.
// Reset: a clearing pass over all TABLE_SIZE slots marks every slot empty; no
// request is accepted during it.
// Stalls: the result register holds one word; a new request is taken while it
// waits, and the finish step waits for it to drain.

module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [KEY_IN_W-1:0]   s_axis_tdata,   // [31:0] key
    input  logic [REQ_W-1:0]      s_axis_tuser,   // [1:0] req_type

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [3:0] slot_index, [7:4] zero
    output logic [STATUS_W-1:0]   m_axis_tuser    // [2:0] status
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int KE    = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    localparam int RW    = TAG_W + KEY_WIDTH;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [REQ_W-1:0]      req_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [IDX_W-1:0]      clr_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      hole_reg;
    logic                  have_hole_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  wr_pend_reg;
    logic [IDX_W-1:0]      wr_addr_reg;
    logic [TAG_W-1:0]      wr_tag_reg;
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [SLOT_IDX_W-1:0] m_slot_reg;

    logic                  s_fire;
    logic                  out_free;
    logic [KEY_WIDTH+KEY_IN_W-1:0] key_wide;
    logic [IDX_W+SLOT_IDX_W-1:0]   slot_wide;

    logic                  home_done;
    logic [IDX_W-1:0]      home;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [RW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [RW-1:0]         ram_rdata;

    // probe evaluation of the slot read last cycle
    logic [TAG_W-1:0]      rd_tag;
    logic [KEY_WIDTH-1:0]  rd_key;
    logic                  is_empty;
    logic                  is_match;
    logic                  have_now;
    logic [IDX_W-1:0]      hole_now;
    logic                  stop;
    logic [IDX_W-1:0]      pos_nxt;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // only the low min(KEY_WIDTH, 32) bits of the key port count, zero-extended to KEY_WIDTH
    assign key_wide  = {{KEY_WIDTH{1'b0}}, KEY_IN_W'(s_axis_tdata[KE-1:0])};
    assign slot_wide = {{SLOT_IDX_W{1'b0}}, idx_reg};

    assign rd_tag   = ram_rdata[RW-1 -: TAG_W];
    assign rd_key   = ram_rdata[KEY_WIDTH-1:0];
    assign is_empty = (rd_tag == TAG_EMPTY);
    assign is_match = (rd_tag == TAG_USED) && (rd_key == key_reg);
    // empty, tombstone or unknown tag all count as a hole
    assign have_now = have_hole_reg || (rd_tag != TAG_USED);
    assign hole_now = have_hole_reg ? hole_reg : pos_reg;
    assign stop     = is_empty || is_match || (cnt_reg == LAST);
    assign pos_nxt  = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;

    // RAM port control
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = pos_nxt;
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = {wr_tag_reg, key_reg};
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {TAG_EMPTY, {KEY_WIDTH{1'b0}}};
            end
            S_HASH: begin
                ram_re    = home_done;
                ram_raddr = home;
            end
            S_PROBE: begin
                ram_re = !stop;
            end
            S_FINISH: begin
                ram_we = out_free && wr_pend_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the finish step reloads the result register itself
            if (m_valid_reg && m_axis_tready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        req_reg     <= s_axis_tuser;
                        key_reg     <= key_wide[KEY_WIDTH-1:0];
                        status_reg  <= STATUS_MISSING;
                        idx_reg     <= '0;
                        wr_pend_reg <= 1'b0;
                        case (s_axis_tuser)
                            REQ_INSERT, REQ_LOOKUP, REQ_DELETE: state_reg <= S_HASH;
                            default:                            state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_HASH: begin
                    if (home_done) begin
                        pos_reg       <= home;
                        cnt_reg       <= '0;
                        have_hole_reg <= 1'b0;
                        state_reg     <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (stop) begin
                        state_reg <= S_FINISH;
                        if (is_match) begin
                            idx_reg <= pos_reg;
                            case (req_reg)
                                REQ_INSERT: status_reg <= STATUS_PRESENT;
                                REQ_LOOKUP: status_reg <= STATUS_FOUND;
                                default: begin
                                    status_reg  <= STATUS_DELETED;
                                    wr_pend_reg <= 1'b1;
                                    wr_addr_reg <= pos_reg;
                                    wr_tag_reg  <= TAG_TOMB;
                                end
                            endcase
                        end else if (req_reg == REQ_INSERT) begin
                            if (have_now) begin
                                status_reg  <= STATUS_INSERTED;
                                idx_reg     <= hole_now;
                                wr_pend_reg <= 1'b1;
                                wr_addr_reg <= hole_now;
                                wr_tag_reg  <= TAG_USED;
                            end else begin
                                status_reg <= STATUS_FULL;
                            end
                        end
                    end else begin
                        pos_reg       <= pos_nxt;
                        cnt_reg       <= cnt_reg + 1'b1;
                        have_hole_reg <= have_now;
                        hole_reg      <= hole_now;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_slot_reg   <= slot_wide[SLOT_IDX_W-1:0];
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    lphs_home #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_W      (KE)
    ) u_home (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_fire),
        .key_in  (s_axis_tdata[KE-1:0]),
        .done    (home_done),
        .home    (home)
    );

    // slot store: tag and key side by side, one entry per slot
    lphs_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_slot_reg};
    assign m_axis_tuser  = m_status_reg;

endmodule

/* test/tb.sv */
// Self-checking bench for linear_probe_hash_set: insert, lookup, delete and
// unused-code words on the stream ports, each checked against a local model of the probe table.
// Depends on lphs_pkg and the linear_probe_hash_set RTL.
`timescale 1ns / 1ps

module tb;
    import lphs_pkg::*;

    localparam int TABLE_SIZE = TABLE_SIZE_DEF;
    localparam int KEY_WIDTH  = KEY_WIDTH_DEF;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;     // unused code, answered as missing, table untouched

    localparam int N_RANDOM   = 450;
    localparam int IDLE_PCT   = 21;
    localparam int HOLD_AT    = 140;    // words sent before the long receiver hold-off
    localparam int HOLD_LEN   = 300;    // cycles of the hold-off
    localparam int CALM_FROM  = 260;    // window of words with no idling on either side
    localparam int CALM_TO    = 360;
    localparam int DRAIN_WAIT = 40;     // wait after the drain, for a late or extra result to show up
    localparam int POOL_N     = 24;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot;
    } set_result_t;

    // Scoreboard: keeps its own copy of the slot tags and keys, predicts the
    // result of every accepted request and checks results in order.
    class set_scoreboard;
        logic [TAG_W-1:0]    slot_tag [TABLE_SIZE];
        logic [KEY_IN_W-1:0] slot_key [TABLE_SIZE];
        set_result_t         awaited_results[$];
        int                  n_bad;
        int                  n_checked;
        int                  status_seen [8];

        function new();
            for (int i = 0; i < TABLE_SIZE; i++) begin
                slot_tag[i] = TAG_EMPTY;
                slot_key[i] = '0;
            end
            n_bad = 0;
            n_checked = 0;
            for (int i = 0; i < 8; i++) status_seen[i] = 0;
        endfunction

        // walk the table for one request, update the copy, queue the result
        function void note_request(logic [REQ_W-1:0] req, logic [KEY_IN_W-1:0] key_in);
            logic [KEY_IN_W-1:0] k;
            int          pos;
            int          hit;
            int          hole;
            bit          found;
            bit          have_hole;
            bit          done;
            set_result_t r;
            k = key_in;
            if (KEY_WIDTH < KEY_IN_W) k = key_in & KEY_IN_W'((64'd1 << KEY_WIDTH) - 1);
            pos = int'(k % TABLE_SIZE);
            hit = 0;
            hole = 0;
            found = 0;
            have_hole = 0;
            done = 0;
            for (int n = 0; n < TABLE_SIZE && !done; n++) begin
                if (slot_tag[pos] == TAG_EMPTY) begin
                    if (!have_hole) begin
                        have_hole = 1;
                        hole = pos;
                    end
                    done = 1;
                end else if (slot_tag[pos] == TAG_USED) begin
                    if (slot_key[pos] == k) begin
                        hit = pos;
                        found = 1;
                        done = 1;
                    end
                end else if (!have_hole) begin
                    // tombstone: first free place for an insert, probe goes on
                    have_hole = 1;
                    hole = pos;
                end
                if (!done) pos = (pos + 1) % TABLE_SIZE;
            end
            r.status = STATUS_MISSING;
            r.slot   = '0;
            case (req)
                REQ_INSERT: begin
                    if (found) begin
                        r.status = STATUS_PRESENT;
                        r.slot   = SLOT_IDX_W'(hit);
                    end else if (!have_hole) begin
                        r.status = STATUS_FULL;
                    end else begin
                        slot_tag[hole] = TAG_USED;
                        slot_key[hole] = k;
                        r.status = STATUS_INSERTED;
                        r.slot   = SLOT_IDX_W'(hole);
                    end
                end
                REQ_LOOKUP: begin
                    if (found) begin
                        r.status = STATUS_FOUND;
                        r.slot   = SLOT_IDX_W'(hit);
                    end
                end
                REQ_DELETE: begin
                    if (found) begin
                        slot_tag[hit] = TAG_TOMB;
                        r.status = STATUS_DELETED;
                        r.slot   = SLOT_IDX_W'(hit);
                    end
                end
                default: ;
            endcase
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_IDX_W-1:0] slot);
            set_result_t want;
            n_checked++;
            status_seen[status]++;
            if (awaited_results.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: unexpected result status %0d slot %0d", $realtime,
                             status, slot);
            end else begin
                want = awaited_results.pop_front();
                if (want.status !== status || want.slot !== slot) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: result %0d mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                                 $realtime, n_checked, want.status, status, want.slot, slot);
                end
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [KEY_IN_W-1:0]   s_axis_tdata;    // [31:0] key
    logic [REQ_W-1:0]      s_axis_tuser;    // [1:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;    // [3:0] slot_index, [7:4] zero
    logic [STATUS_W-1:0]   m_axis_tuser;    // [2:0] status

    set_scoreboard sb;
    int            n_sent;
    logic          calm;                    // no idling on either side
    logic [KEY_IN_W-1:0] key_pool [POOL_N];

    linear_probe_hash_set #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    assign calm = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);

    // Offer one request word. Called at a falling edge, returns at a falling
    // edge; tvalid stays high into the next call when no idle cycle is drawn.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_IN_W-1:0] key_in);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key_in;
        s_axis_tuser  <= req;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_request(req, key_in);
        n_sent++;
        @(negedge aclk);
    endtask

    // Receiver: random back-pressure, one long hold-off so the result register
    // fills and the block stops taking requests, and a calm window.
    initial begin : receiver
        bit held;
        held = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && n_sent >= HOLD_AT) begin
                held = 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
            end
            if (calm) m_axis_tready <= 1'b1;
            else      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result monitor: sampled at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[SLOT_IDX_W-1:0]);
    end

    // Safety net: far beyond the slowest legal run.
    initial begin : watchdog
        #2ms;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("linear_probe_hash_set test failed");
        $finish;
    end

    initial begin : stimulus
        int r;
        logic [REQ_W-1:0]    req;
        logic [KEY_IN_W-1:0] k;
        sb = new();
        n_sent = 0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part ---
        send_request(REQ_INSERT, 32'h0000_0000);    // lowest key, home 0
        send_request(REQ_INSERT, 32'hFFFF_FFFF);    // highest key, home 15
        send_request(REQ_INSERT, 32'h0000_0010);    // collides with 0, lands in 1
        send_request(REQ_INSERT, 32'h0000_001F);    // home 15, wraps past 0 and 1 to 2
        send_request(REQ_INSERT, 32'h0000_0010);    // duplicate insert
        send_request(REQ_LOOKUP, 32'h0000_001F);    // found after wrap
        send_request(REQ_LOOKUP, 32'h0000_002F);    // miss, stops at empty slot
        send_request(REQ_DELETE, 32'h0000_0010);    // leaves a tombstone in 1
        send_request(REQ_DELETE, 32'h0000_0010);    // delete miss
        send_request(REQ_LOOKUP, 32'h0000_001F);    // probe must pass the tombstone
        send_request(REQ_SPARE,  32'h0000_0000);    // unused request code, answered as missing
        send_request(REQ_INSERT, 32'h0000_002F);    // reuses the tombstone
        // fill slots 3..14, then the table is full
        for (int i = 3; i < TABLE_SIZE - 1; i++)
            send_request(REQ_INSERT, {28'($urandom), 4'(i)});
        send_request(REQ_INSERT, 32'hA5A5_5A5A);    // full table
        send_request(REQ_LOOKUP, 32'h5A5A_A5A5);    // miss after a full lap

        // --- random part: a small key pool with clustered homes keeps the
        // table near full, so collisions, tombstones and full laps recur ---
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = (i % 2) ? $urandom : {28'($urandom), 4'($urandom_range(0, 5))};
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 99) begin
                for (int j = 0; j < 4; j++)
                    key_pool[$urandom_range(POOL_N - 1)] = $urandom;
            end
            r = $urandom_range(99);
            if (r < 38)      req = REQ_INSERT;
            else if (r < 63) req = REQ_LOOKUP;
            else if (r < 95) req = REQ_DELETE;
            else             req = REQ_SPARE;
            r = $urandom_range(99);
            if (r < 85)      k = key_pool[$urandom_range(POOL_N - 1)];
            else if (r < 87) k = (r == 85) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            else             k = $urandom;
            send_request(req, k);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give a late or extra result time to show up
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 n_sent, sb.n_checked, sb.n_bad);
        $display("statuses: inserted %0d, present %0d, full %0d, found %0d, missing %0d, deleted %0d",
                 sb.status_seen[STATUS_INSERTED], sb.status_seen[STATUS_PRESENT],
                 sb.status_seen[STATUS_FULL], sb.status_seen[STATUS_FOUND],
                 sb.status_seen[STATUS_MISSING], sb.status_seen[STATUS_DELETED]);
        if (sb.n_bad == 0 && sb.pending() == 0)
            $display("linear_probe_hash_set test passed");
        else
            $display("linear_probe_hash_set test failed");
        $finish;
    end

endmodule

/* linear_probe_hash_set.f */
rtl/core/lphs_pkg.sv
rtl/core/lphs_ram.sv
rtl/core/lphs_home.sv
rtl/core/linear_probe_hash_set.sv
test/tb.sv
